// File: rtl/sls_pkg.sv
// shared types and constants for the 2x2 linear system solver
// no dependencies
package sls_pkg;

    localparam int WORD_W = 32;
    localparam int WIDE_W = 64;
    localparam int QUO_W  = 32;

    typedef struct packed {
        logic [WIDE_W-1:0] rem;
        logic [WIDE_W-1:0] dm;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
        logic              neg;
        logic              big;
    } lane_t;

endpackage

// File: rtl/linear_system_2x2_solver_top.sv
// 2x2 solver by cramer's rule: det and numerators, then two chains of 32 division cells
// done is registered with the results, behind the input, product, prep, division-cell and output registers
// throughput: one system per cycle, busy is always low; the division chains set the depth
// reset: rst_n clears the valid line and done only, so no strobe follows reset
// depends on sls_pkg, sls_prod, sls_div_cell
module linear_system_2x2_solver_top
    import sls_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [WORD_W-1:0] a00,
    input  logic signed [WORD_W-1:0] a01,
    input  logic signed [WORD_W-1:0] a10,
    input  logic signed [WORD_W-1:0] a11,
    input  logic signed [WORD_W-1:0] b0,
    input  logic signed [WORD_W-1:0] b1,
    output logic                     done,
    output logic signed [WORD_W-1:0] x0,
    output logic signed [WORD_W-1:0] x1,
    output logic signed [WIDE_W-1:0] det,
    output logic                     singular,
    output logic                     overflow
);

    localparam int VLD_N = 4 + QUO_W;
    localparam int LAT   = VLD_N + 1;

    logic [VLD_N-1:0] vld_reg;
    logic signed [WORD_W-1:0] a00_reg, a01_reg, a10_reg, a11_reg, b0_reg, b1_reg;
    logic signed [WIDE_W-1:0] det_w, n0_w, n1_w;
    logic signed [WIDE_W-1:0] det_line_reg [QUO_W+1];
    lane_t chain [2][QUO_W+1];
    lane_t prep_next [2];
    logic [WIDE_W-1:0] dmag;
    logic [WIDE_W-1:0] nmag [2];
    logic [WIDE_W+WORD_W-1:0] nwide [2];
    logic signed [WIDE_W-1:0] nsel [2];

    logic                     done_reg;
    logic signed [WORD_W-1:0] x_reg [2];
    logic signed [WORD_W-1:0] x_next [2];
    logic signed [WIDE_W-1:0] det_reg;
    logic                     sing_reg, ovf_reg;
    logic                     sing_next, ovf_next;
    logic                     lane_ovf [2];
    logic [QUO_W:0]           lim [2];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[VLD_N-2:0], start};
            done_reg <= vld_reg[VLD_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        a00_reg <= a00;
        a01_reg <= a01;
        a10_reg <= a10;
        a11_reg <= a11;
        b0_reg  <= b0;
        b1_reg  <= b1;
    end

    sls_prod u_prod (
        .clk (clk),
        .a00 (a00_reg),
        .a01 (a01_reg),
        .a10 (a10_reg),
        .a11 (a11_reg),
        .b0  (b0_reg),
        .b1  (b1_reg),
        .det (det_w),
        .n0  (n0_w),
        .n1  (n1_w)
    );

    // magnitudes and the first partial remainder; big means the quotient needs more than 32 bits
    assign nsel[0] = n0_w;
    assign nsel[1] = n1_w;
    assign dmag = det_w[WIDE_W-1] ? WIDE_W'(-det_w) : WIDE_W'(det_w);

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            nmag[l]  = nsel[l][WIDE_W-1] ? WIDE_W'(-nsel[l]) : WIDE_W'(nsel[l]);
            nwide[l] = {{WORD_W{1'b0}}, nmag[l]} << FRAC_BITS;
            prep_next[l].rem = nwide[l][WIDE_W+WORD_W-1:WORD_W];
            prep_next[l].dm  = dmag;
            prep_next[l].num = nwide[l][QUO_W-1:0];
            prep_next[l].quo = '0;
            prep_next[l].neg = nsel[l][WIDE_W-1] ^ det_w[WIDE_W-1];
            prep_next[l].big = (nwide[l][WIDE_W+WORD_W-1:WORD_W] >= dmag);
        end
    end

    always_ff @(posedge clk)
    begin
        chain[0][0]     <= prep_next[0];
        chain[1][0]     <= prep_next[1];
        det_line_reg[0] <= det_w;
        for (int k = 1; k <= QUO_W; k++)
            det_line_reg[k] <= det_line_reg[k-1];
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        for (genvar k = 0; k < QUO_W; k++)
        begin : g_cell
            sls_div_cell u_cell (
                .clk  (clk),
                .din  (chain[l][k]),
                .dout (chain[l][k+1])
            );
        end
    end

    always_comb
    begin
        sing_next = (det_line_reg[QUO_W] == '0);
        for (int l = 0; l < 2; l++)
        begin
            lim[l] = chain[l][QUO_W].neg ? {1'b0, 1'b1, {(QUO_W-1){1'b0}}}
                                         : {2'b00, {(QUO_W-1){1'b1}}};
            lane_ovf[l] = chain[l][QUO_W].big || ({1'b0, chain[l][QUO_W].quo} > lim[l]);
            if (sing_next)
                x_next[l] = '0;
            else if (lane_ovf[l])
                x_next[l] = chain[l][QUO_W].neg ? {1'b1, {(WORD_W-1){1'b0}}}
                                                : {1'b0, {(WORD_W-1){1'b1}}};
            else if (chain[l][QUO_W].neg)
                x_next[l] = WORD_W'(-chain[l][QUO_W].quo);
            else
                x_next[l] = WORD_W'(chain[l][QUO_W].quo);
        end
        ovf_next = !sing_next && (lane_ovf[0] || lane_ovf[1]);
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= x_next[0];
        x_reg[1] <= x_next[1];
        det_reg  <= det_line_reg[QUO_W];
        sing_reg <= sing_next;
        ovf_reg  <= ovf_next;
    end

    assign done     = done_reg;
    assign x0       = x_reg[0];
    assign x1       = x_reg[1];
    assign det      = det_reg;
    assign singular = sing_reg;
    assign overflow = ovf_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("result strobe missing after accepted transaction");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (x0 == '0 && x1 == '0 && det == '0 && !overflow))
        else $error("singular result not cleared");

    a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !singular) |-> (det != '0))
        else $error("nonsingular result with zero determinant");

    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vld_reg[VLD_N-1]))
        else $error("strobe without transaction in flight");

endmodule

// File: rtl/sls_prod.sv
// cross products, determinant and adjugate numerators, two register stages
// depends on sls_pkg
module sls_prod
    import sls_pkg::*;
(
    input  logic                     clk,
    input  logic signed [WORD_W-1:0] a00,
    input  logic signed [WORD_W-1:0] a01,
    input  logic signed [WORD_W-1:0] a10,
    input  logic signed [WORD_W-1:0] a11,
    input  logic signed [WORD_W-1:0] b0,
    input  logic signed [WORD_W-1:0] b1,
    output logic signed [WIDE_W-1:0] det,
    output logic signed [WIDE_W-1:0] n0,
    output logic signed [WIDE_W-1:0] n1
);

    logic signed [WIDE_W-1:0] p_reg [6];
    logic signed [WIDE_W-1:0] det_reg, n0_reg, n1_reg;

    always_ff @(posedge clk)
    begin
        p_reg[0] <= WIDE_W'(a00) * WIDE_W'(a11);
        p_reg[1] <= WIDE_W'(a01) * WIDE_W'(a10);
        p_reg[2] <= WIDE_W'(a11) * WIDE_W'(b0);
        p_reg[3] <= WIDE_W'(a01) * WIDE_W'(b1);
        p_reg[4] <= WIDE_W'(a00) * WIDE_W'(b1);
        p_reg[5] <= WIDE_W'(a10) * WIDE_W'(b0);
        det_reg  <= p_reg[0] - p_reg[1];
        n0_reg   <= p_reg[2] - p_reg[3];
        n1_reg   <= p_reg[4] - p_reg[5];
    end

    assign det = det_reg;
    assign n0  = n0_reg;
    assign n1  = n1_reg;

endmodule

// File: rtl/sls_div_cell.sv
// one restoring division step: shifts in a dividend bit, produces one quotient bit
// depends on sls_pkg
module sls_div_cell
    import sls_pkg::*;
(
    input  logic  clk,
    input  lane_t din,
    output lane_t dout
);

    logic [WIDE_W:0] trial;
    logic [WIDE_W:0] diff;
    logic            qbit;
    lane_t           cell_reg, cell_next;

    always_comb
    begin
        trial = {din.rem, din.num[QUO_W-1]};
        diff  = trial - {1'b0, din.dm};
        qbit  = (trial >= {1'b0, din.dm});
        cell_next      = din;
        cell_next.rem  = qbit ? diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
        cell_next.num  = {din.num[QUO_W-2:0], 1'b0};
        cell_next.quo  = {din.quo[QUO_W-2:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

// File: sim/linear_system_2x2_solver_top_tb.sv
// testbench for the 2x2 cramer's rule solver: random and corner systems, scoreboard check
// depends on sls_pkg and linear_system_2x2_solver_top
`timescale 1ns / 100ps

module linear_system_2x2_solver_top_tb;
    import sls_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 37;

    typedef struct {
        logic signed [WORD_W-1:0] a00, a01, a10, a11, b0, b1;
    } system_t;

    typedef struct {
        logic signed [WORD_W-1:0] x0, x1;
        logic signed [WIDE_W-1:0] det;
        logic singular, overflow;
    } solution_t;

    logic clk, rst_n, start, busy, done, singular, overflow;
    logic signed [WORD_W-1:0] a00, a01, a10, a11, b0, b1, x0, x1;
    logic signed [WIDE_W-1:0] det;

    system_t   pending_systems[$];
    solution_t expected_solutions[$];
    int  errors = 0;
    bit  hold_off = 0;
    int  burst_left = 0;
    int  gap_left = 0;

    linear_system_2x2_solver_top #(.FRAC_BITS(FRAC)) dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // quotient (num << FRAC) / den, truncated toward zero, saturated to 32 bits
    function automatic logic signed [WORD_W-1:0] fixed_quotient(
        input logic signed [WIDE_W-1:0] num, input logic signed [WIDE_W-1:0] den,
        inout logic ovf);
        logic [127:0] nm, dm, q;
        logic neg;
        logic [127:0] lim;
        // magnitude as unsigned so the most negative value stays positive
        nm  = 128'($unsigned(num < 0 ? -num : num));
        dm  = 128'($unsigned(den < 0 ? -den : den));
        neg = (num < 0) != (den < 0);
        q   = (nm << FRAC) / dm;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
        begin
            q = lim;
            ovf = 1;
        end
        return neg ? WORD_W'(-q) : WORD_W'(q);
    endfunction

    function automatic solution_t solve_system(input system_t s);
        solution_t r;
        logic signed [WIDE_W-1:0] d, n0, n1;
        d  = WIDE_W'(s.a00) * s.a11 - WIDE_W'(s.a01) * s.a10;
        n0 = WIDE_W'(s.a11) * s.b0 - WIDE_W'(s.a01) * s.b1;
        n1 = WIDE_W'(s.a00) * s.b1 - WIDE_W'(s.a10) * s.b0;
        r.overflow = 0;
        r.det = d;
        r.singular = (d == 0);
        if (d == 0)
        begin
            r.x0 = 0;
            r.x1 = 0;
        end
        else
        begin
            r.x0 = fixed_quotient(n0, d, r.overflow);
            r.x1 = fixed_quotient(n1, d, r.overflow);
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 8)) - 4) << FRAC;
            3: return 0;
            4: return 32'($urandom_range(0, 511)) - 256;
            5: return 32'(int'($urandom_range(0, 200000)) - 100000) << 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_system(input logic [WORD_W-1:0] p, q, r, s, u, v);
        system_t t;
        t = '{p, q, r, s, u, v};
        pending_systems.push_back(t);
    endtask

    initial
    begin
        system_t t;
        int k;
        add_system(32'h10000, 0, 0, 32'h10000, 32'h30000, 32'hFFFE0000);
        add_system(32'h10000, 32'h20000, 32'h20000, 32'h40000, 5, 7);
        add_system(0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
        add_system(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1, 1);
        add_system(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                   32'h80000000, 32'h7FFFFFFF);
        add_system(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
        add_system(1, 0, 0, 1, 32'h7FFFFFFF, 32'h80000000);
        add_system(1, 0, 0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        add_system(32'h80000000, 0, 0, 1, 32'h80000000, 32'h80000000);
        add_system(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 2);
        add_system(32'h30000, 32'h10000, 32'h10000, 32'h20000, 32'h90000, 32'h80000);
        add_system(32'hFFFF0000, 32'h8000, 32'h18000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1);
        for (k = 0; k < 1650; k++)
        begin
            t = '{pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value(), pick_value()};
            // some singular systems: second row a multiple of the first
            if ($urandom_range(0, 15) == 0)
            begin
                t.a10 = t.a00;
                t.a11 = t.a01;
            end
            pending_systems.push_back(t);
            if (k == 800)
            begin
                wait (pending_systems.size() == 0);
                hold_off = 1;
                wait (expected_solutions.size() == 0);
                hold_off = 0;
            end
        end
        wait (pending_systems.size() == 0 && expected_solutions.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 0;
        start = 0;
        {a00, a01, a10, a11, b0, b1} = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    // driver: bursts with random gaps, one transaction accepted per edge when start is high
    always @(negedge clk)
    begin
        system_t t;
        if (rst_n)
        begin
            if (start && !busy)
                void'(pending_systems.pop_front());
            if (gap_left > 0)
                gap_left--;
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            end
            if (pending_systems.size() > 0 && gap_left == 0 && !hold_off)
            begin
                t = pending_systems[0];
                {a00, a01, a10, a11, b0, b1} <= {t.a00, t.a01, t.a10, t.a11, t.b0, t.b1};
                start <= 1;
                burst_left--;
            end
            else
                start <= 0;
        end
    end

    // monitor: predictions on accepted transactions, compare on done
    always @(posedge clk)
    begin
        system_t   t;
        solution_t e;
        if (rst_n && done)
        begin
            if (expected_solutions.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                e = expected_solutions.pop_front();
                if (x0 !== e.x0)
                begin
                    $error("x0 expected %h actual %h", e.x0, x0);
                    errors++;
                end
                if (x1 !== e.x1)
                begin
                    $error("x1 expected %h actual %h", e.x1, x1);
                    errors++;
                end
                if (det !== e.det)
                begin
                    $error("det expected %h actual %h", e.det, det);
                    errors++;
                end
                if (singular !== e.singular)
                begin
                    $error("singular expected %b actual %b", e.singular, singular);
                    errors++;
                end
                if (overflow !== e.overflow)
                begin
                    $error("overflow expected %b actual %b", e.overflow, overflow);
                    errors++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            t = '{a00, a01, a10, a11, b0, b1};
            expected_solutions.push_back(solve_system(t));
        end
    end

endmodule
